FILE: rtl/core/sta_pkg.sv
// shared types and constants for the session table with aging
`timescale 1ns / 1ps

package sta_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned USER_W   = 16;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned EXP_W    = 7;

  localparam logic [TMO_W-1:0]         TIMEOUT_RESET = 16'd300;
  localparam logic signed [USER_W-1:0] NONE_USER     = -16'sd1;

  typedef enum logic [2:0] {
    OP_TOUCH  = 3'd0,
    OP_LOGIN  = 3'd1,
    OP_LOGOUT = 3'd2,
    OP_QUERY  = 3'd3,
    OP_TICK   = 3'd4,
    OP_SWEEP  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_addr;
    logic need_scan;
  } stat_t;

endpackage

FILE: rtl/core/sta_req_if.sv
// request channel: one session operation per beat
`timescale 1ns / 1ps

interface sta_req_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          op;
  logic [15:0]                         addr_family;
  logic [15:0]                         port;
  logic [31:0]                         ip_addr;
  logic signed [sta_pkg::USER_W-1:0]   login_user;

  modport source (output valid, op, addr_family, port, ip_addr, login_user, input ready);
  modport sink   (input valid, op, addr_family, port, ip_addr, login_user, output ready);
endinterface

FILE: rtl/core/sta_rsp_if.sv
// response channel: one result per beat
`timescale 1ns / 1ps

interface sta_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [sta_pkg::SLOT_W-1:0]          slot;
  logic signed [sta_pkg::USER_W-1:0]   user_out;
  logic                                logged_in;
  logic [sta_pkg::EXP_W-1:0]           expired_count;

  modport source (output valid, status, slot, user_out, logged_in, expired_count, input ready);
  modport sink   (input valid, status, slot, user_out, logged_in, expired_count, output ready);
endinterface

FILE: rtl/core/sta_ctrl.sv
// control state machine: clearing pass, slot scan and result handoff
`timescale 1ns / 1ps

module sta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sta_pkg::stat_t stat_i,
  output sta_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.finish = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.last_addr) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.need_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (stat_i.last_addr) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (cmd_o.finish) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/sta_dp.sv
// datapath: slot memories, scan trackers, time counter and result register
`timescale 1ns / 1ps

module sta_dp #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [2:0]                          in_op_i,
  input  logic [15:0]                         in_addr_family_i,
  input  logic [15:0]                         in_port_i,
  input  logic [31:0]                         in_ip_addr_i,
  input  logic signed [sta_pkg::USER_W-1:0]   in_login_user_i,
  input  logic                                cfg_we_i,
  input  logic [sta_pkg::TMO_W-1:0]           cfg_wdata_i,
  input  sta_pkg::cmd_t                       cmd_i,
  output sta_pkg::stat_t                      stat_o,
  output logic [1:0]                          res_status_o,
  output logic [sta_pkg::SLOT_W-1:0]          res_slot_o,
  output logic signed [sta_pkg::USER_W-1:0]   res_user_o,
  output logic                                res_logged_in_o,
  output logic [sta_pkg::EXP_W-1:0]           res_expired_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // slot memories
  logic [sta_pkg::KEY_W-1:0]         key_mem  [SLOTS];
  logic signed [sta_pkg::USER_W-1:0] user_mem [SLOTS];
  logic [TIME_BITS-1:0]              seen_mem [SLOTS];
  logic                              act_mem  [SLOTS];

  logic [sta_pkg::KEY_W-1:0]         key_rd_q;
  logic signed [sta_pkg::USER_W-1:0] user_rd_q;
  logic [TIME_BITS-1:0]              seen_rd_q;
  logic                              act_rd_q;

  // item and scan state
  logic [2:0]                        op_q;
  logic [sta_pkg::KEY_W-1:0]         key_q;
  logic signed [sta_pkg::USER_W-1:0] user_in_q;
  logic [IDX_W-1:0]                  cnt_q;
  logic                              rd_valid_q;
  logic [IDX_W-1:0]                  rd_idx_q;
  logic                              found_q;
  logic [IDX_W-1:0]                  match_idx_q;
  logic signed [sta_pkg::USER_W-1:0] match_user_q;
  logic                              free_q;
  logic [IDX_W-1:0]                  free_idx_q;
  logic [sta_pkg::EXP_W-1:0]         expired_q;
  logic [TIME_BITS-1:0]              now_q;
  logic [sta_pkg::TMO_W-1:0]         timeout_q;

  logic [1:0]                        res_status_q, res_status_d;
  logic [sta_pkg::SLOT_W-1:0]        res_slot_q;
  logic signed [sta_pkg::USER_W-1:0] res_user_q, res_user_d;
  logic [sta_pkg::EXP_W-1:0]         res_expired_q, res_expired_d;

  logic                              hit, expire, is_find, slot_hit;
  logic [TIME_BITS-1:0]              age;
  logic [IDX_W-1:0]                  wr_idx;
  logic [IDX_W+sta_pkg::SLOT_W-1:0]  slot_ext;
  logic                              key_we, user_we, seen_we, act_we, act_wdata;
  logic [IDX_W-1:0]                  act_waddr;
  logic signed [sta_pkg::USER_W-1:0] user_wdata;

  assign stat_o.last_addr = (cnt_q == LAST_IDX);
  assign stat_o.need_scan = (in_op_i == sta_pkg::OP_TOUCH) || (in_op_i == sta_pkg::OP_LOGIN) ||
                            (in_op_i == sta_pkg::OP_LOGOUT) || (in_op_i == sta_pkg::OP_QUERY) ||
                            (in_op_i == sta_pkg::OP_SWEEP);

  assign hit    = rd_valid_q && act_rd_q && (key_rd_q == key_q);
  assign age    = now_q - seen_rd_q;
  assign expire = rd_valid_q && act_rd_q && (op_q == sta_pkg::OP_SWEEP) &&
                  (age > TIME_BITS'(timeout_q));
  assign is_find = (op_q == sta_pkg::OP_TOUCH) || (op_q == sta_pkg::OP_LOGIN);
  assign wr_idx  = found_q ? match_idx_q : free_idx_q;

  // result of the finished item
  always_comb begin
    res_status_d  = sta_pkg::STAT_OK;
    res_user_d    = sta_pkg::NONE_USER;
    res_expired_d = '0;
    slot_hit      = 1'b0;
    case (op_q)
      sta_pkg::OP_TOUCH, sta_pkg::OP_LOGIN: begin
        if (found_q || free_q) begin
          slot_hit = 1'b1;
          if (op_q == sta_pkg::OP_LOGIN) res_user_d = user_in_q;
          else if (found_q)              res_user_d = match_user_q;
        end else begin
          res_status_d = sta_pkg::STAT_FULL;
        end
      end
      sta_pkg::OP_LOGOUT: begin
        if (found_q) slot_hit = 1'b1;
        else         res_status_d = sta_pkg::STAT_NOT_FOUND;
      end
      sta_pkg::OP_QUERY: begin
        if (found_q) begin
          slot_hit   = 1'b1;
          res_user_d = match_user_q;
        end else begin
          res_status_d = sta_pkg::STAT_NOT_FOUND;
        end
      end
      sta_pkg::OP_SWEEP: begin
        res_expired_d = expired_q;
      end
      default: begin
        res_expired_d = '0;
      end
    endcase
    slot_ext = slot_hit ? {{sta_pkg::SLOT_W{1'b0}}, wr_idx} : '0;
  end

  // memory write controls
  always_comb begin
    key_we     = cmd_i.finish && is_find && !found_q && free_q;
    seen_we    = cmd_i.finish && is_find && (found_q || free_q);
    user_we    = cmd_i.finish && is_find &&
                 (found_q ? (op_q == sta_pkg::OP_LOGIN) : free_q);
    user_wdata = (op_q == sta_pkg::OP_LOGIN) ? user_in_q : sta_pkg::NONE_USER;
    act_we     = 1'b0;
    act_waddr  = cnt_q;
    act_wdata  = 1'b0;
    if (cmd_i.clear) begin
      act_we = 1'b1;
    end else if (expire) begin
      act_we    = 1'b1;
      act_waddr = rd_idx_q;
    end else if (key_we) begin
      act_we    = 1'b1;
      act_waddr = free_idx_q;
      act_wdata = 1'b1;
    end else if (cmd_i.finish && (op_q == sta_pkg::OP_LOGOUT) && found_q) begin
      act_we    = 1'b1;
      act_waddr = match_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we)  key_mem[wr_idx]   <= key_q;
    if (user_we) user_mem[wr_idx]  <= user_wdata;
    if (seen_we) seen_mem[wr_idx]  <= now_q;
    if (act_we)  act_mem[act_waddr] <= act_wdata;
    if (cmd_i.scan) begin
      key_rd_q  <= key_mem[cnt_q];
      user_rd_q <= user_mem[cnt_q];
      seen_rd_q <= seen_mem[cnt_q];
      act_rd_q  <= act_mem[cnt_q];
    end
  end

  // item latch and trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= sta_pkg::OP_TICK;
      cnt_q      <= '0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
      expired_q  <= '0;
      now_q      <= '0;
      timeout_q  <= sta_pkg::TIMEOUT_RESET;
    end else begin
      rd_valid_q <= cmd_i.scan;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (cmd_i.clear || cmd_i.scan) begin
        cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        op_q      <= in_op_i;
        cnt_q     <= '0;
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        expired_q <= '0;
      end else begin
        if (hit && !found_q) found_q <= 1'b1;
        if (rd_valid_q && !act_rd_q && !free_q) free_q <= 1'b1;
        if (expire) expired_q <= expired_q + 1'b1;
      end
      if (cmd_i.finish && (op_q == sta_pkg::OP_TICK)) now_q <= now_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q     <= {in_addr_family_i, in_port_i, in_ip_addr_i};
      user_in_q <= in_login_user_i;
    end
    if (hit && !found_q) begin
      match_idx_q  <= rd_idx_q;
      match_user_q <= user_rd_q;
    end
    if (rd_valid_q && !act_rd_q && !free_q) free_idx_q <= rd_idx_q;
    if (cmd_i.scan) rd_idx_q <= cnt_q;
    if (cmd_i.finish) begin
      res_status_q  <= res_status_d;
      res_slot_q    <= slot_ext[sta_pkg::SLOT_W-1:0];
      res_user_q    <= res_user_d;
      res_expired_q <= res_expired_d;
    end
  end

  assign res_status_o    = res_status_q;
  assign res_slot_o      = res_slot_q;
  assign res_user_o      = res_user_q;
  assign res_logged_in_o = (res_user_q != sta_pkg::NONE_USER);
  assign res_expired_o   = res_expired_q;

endmodule

FILE: rtl/core/session_table_with_aging.sv
// session table with aging: top level
// tick and unknown ops go from idle straight to the done state;
//   lookup ops and sweep first run the one-slot-per-cycle memory scan over all SLOTS slots
// one item at a time: no new request is taken until the previous item has finished
// reset: asynchronous, active low; afterwards a clearing pass over all slots empties
//   the active marks while the request channel is held not ready
`timescale 1ns / 1ps

module session_table_with_aging #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sta_req_if.sink                     req_i,
  sta_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [sta_pkg::TMO_W-1:0]   cfg_wdata_i
);

  sta_pkg::cmd_t  cmd;
  sta_pkg::stat_t stat;

  sta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sta_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_op_i          (req_i.op),
    .in_addr_family_i (req_i.addr_family),
    .in_port_i        (req_i.port),
    .in_ip_addr_i     (req_i.ip_addr),
    .in_login_user_i  (req_i.login_user),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .res_status_o     (rsp_o.status),
    .res_slot_o       (rsp_o.slot),
    .res_user_o       (rsp_o.user_out),
    .res_logged_in_o  (rsp_o.logged_in),
    .res_expired_o    (rsp_o.expired_count)
  );

`ifndef SYNTHESIS
  a_one_item_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while an item is in flight");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != sta_pkg::STAT_OK) |->
      (rsp_o.slot == '0) && !rsp_o.logged_in && (rsp_o.user_out == sta_pkg::NONE_USER))
    else $error("error result carries session fields");

  a_logged_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.logged_in == (rsp_o.user_out != sta_pkg::NONE_USER))
    else $error("logged_in disagrees with user id");

  a_expired_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.expired_count != '0) |->
      (rsp_o.status == sta_pkg::STAT_OK) && (rsp_o.slot == '0))
    else $error("expired count on a non-sweep result");
`endif

endmodule

FILE: verif/tb_top.sv
// testbench for the session table: shadow table, random request mix, reply checking
`timescale 1ns / 1ps

localparam int unsigned SESSION_SLOTS = 64;
localparam logic [2:0]  OP_UNUSED_LO  = 3'd6;
localparam logic [2:0]  OP_UNUSED_HI  = 3'd7;

typedef struct {
  sta_pkg::status_e   status;
  logic [5:0]         slot;
  logic signed [15:0] user_out;
  logic               logged_in;
  logic [6:0]         expired_count;
} session_reply_t;

class session_shadow;
  logic [63:0]        keys      [SESSION_SLOTS];
  logic signed [15:0] users     [SESSION_SLOTS];
  logic [31:0]        last_seen [SESSION_SLOTS];
  bit                 active    [SESSION_SLOTS];
  logic [31:0]        now_ticks;
  logic [15:0]        timeout_ticks;
  session_reply_t     pending_replies [$];
  int                 errors;

  function new();
    foreach (active[i]) active[i] = 1'b0;
    now_ticks     = '0;
    timeout_ticks = sta_pkg::TIMEOUT_RESET;
    errors        = 0;
  endfunction

  function void set_timeout(logic [15:0] value);
    timeout_ticks = value;
  endfunction

  function int pending();
    return pending_replies.size();
  endfunction

  function int find_active(logic [63:0] key);
    for (int i = 0; i < SESSION_SLOTS; i++)
      if (active[i] && keys[i] == key) return i;
    return -1;
  endfunction

  function void apply_request(logic [2:0] op, logic [63:0] key, logic signed [15:0] user);
    session_reply_t r;
    int             idx;
    logic [31:0]    age;
    r.status        = sta_pkg::STAT_OK;
    r.slot          = '0;
    r.user_out      = sta_pkg::NONE_USER;
    r.logged_in     = 1'b0;
    r.expired_count = '0;
    case (op)
      sta_pkg::OP_TOUCH, sta_pkg::OP_LOGIN: begin
        idx = find_active(key);
        if (idx < 0) begin
          for (int i = 0; i < SESSION_SLOTS && idx < 0; i++)
            if (!active[i]) idx = i;
          if (idx >= 0) begin
            keys[idx]   = key;
            users[idx]  = sta_pkg::NONE_USER;
            active[idx] = 1'b1;
          end
        end
        if (idx < 0) begin
          r.status = sta_pkg::STAT_FULL;
        end else begin
          last_seen[idx] = now_ticks;
          if (op == sta_pkg::OP_LOGIN) users[idx] = user;
          r.slot      = idx[5:0];
          r.user_out  = users[idx];
          r.logged_in = (users[idx] != sta_pkg::NONE_USER);
        end
      end
      sta_pkg::OP_LOGOUT: begin
        idx = find_active(key);
        if (idx < 0) begin
          r.status = sta_pkg::STAT_NOT_FOUND;
        end else begin
          active[idx] = 1'b0;
          r.slot      = idx[5:0];
        end
      end
      sta_pkg::OP_QUERY: begin
        idx = find_active(key);
        if (idx < 0) begin
          r.status = sta_pkg::STAT_NOT_FOUND;
        end else begin
          r.slot      = idx[5:0];
          r.user_out  = users[idx];
          r.logged_in = (users[idx] != sta_pkg::NONE_USER);
        end
      end
      sta_pkg::OP_TICK: now_ticks = now_ticks + 32'd1;
      sta_pkg::OP_SWEEP: begin
        for (int i = 0; i < SESSION_SLOTS; i++) begin
          age = now_ticks - last_seen[i];
          if (active[i] && age > {16'd0, timeout_ticks}) begin
            active[i]       = 1'b0;
            r.expired_count = r.expired_count + 7'd1;
          end
        end
      end
      default: ;
    endcase
    pending_replies.push_back(r);
  endfunction

  function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void match_reply(logic [1:0] status, logic [5:0] slot, logic signed [15:0] user_out,
                            logic logged_in, logic [6:0] expired_count);
    session_reply_t r;
    if (pending_replies.size() == 0) begin
      $display("%0t: reply beat with nothing outstanding, expected none, got status %0d",
               $time, status);
      errors++;
    end else begin
      r = pending_replies.pop_front();
      compare_field("status", r.status, status);
      compare_field("slot", r.slot, slot);
      compare_field("user_out", r.user_out, user_out);
      compare_field("logged_in", r.logged_in, logged_in);
      compare_field("expired_count", r.expired_count, expired_count);
    end
  endfunction
endclass

module tb_top;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  bit          no_idle;
  logic [63:0] key_pool [96];

  session_shadow shadow;

  sta_req_if req_if ();
  sta_rsp_if rsp_if ();

  session_table_with_aging #(
    .SLOTS     (SESSION_SLOTS),
    .TIME_BITS (32)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_request(logic [2:0] op, logic [63:0] key, logic signed [15:0] user);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.op          <= op;
    req_if.addr_family <= key[63:48];
    req_if.port        <= key[47:32];
    req_if.ip_addr     <= key[31:0];
    req_if.login_user  <= user;
    req_if.valid       <= 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    shadow.apply_request(op, key, user);
    @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    req_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.set_timeout(value);
  endtask

  task automatic run_traffic(int n_items, int pool_n, bit allow_logout, bit fill);
    logic [63:0]        key;
    logic [2:0]         op;
    logic signed [15:0] user;
    int                 pick;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      user = ($urandom_range(0, 4) == 0) ? sta_pkg::NONE_USER :
                                           16'($urandom_range(0, 32767));
      pick = $urandom_range(0, 99);
      if (fill && pick < 85) op = sta_pkg::OP_TOUCH;
      else begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = sta_pkg::OP_TOUCH;
        else if (pick < 48) op = sta_pkg::OP_LOGIN;
        else if (pick < 58) op = allow_logout ? sta_pkg::OP_LOGOUT : sta_pkg::OP_QUERY;
        else if (pick < 72) op = sta_pkg::OP_QUERY;
        else if (pick < 88) op = sta_pkg::OP_TICK;
        else if (pick < 96) op = sta_pkg::OP_SWEEP;
        else op = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end
      send_request(op, key, user);
    end
  endtask

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      shadow.match_reply(rsp_if.status, rsp_if.slot, rsp_if.user_out, rsp_if.logged_in,
                         rsp_if.expired_count);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [63:0] k_zero, k_ones, k_alt_a, k_alt_b;
    k_zero  = 64'h0;
    k_ones  = '1;
    k_alt_a = 64'h5555_AAAA_5555_AAAA;
    k_alt_b = 64'hAAAA_5555_AAAA_5555;
    shadow  = new();
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    no_idle            = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = sta_pkg::OP_TOUCH;
    req_if.addr_family = '0;
    req_if.port        = '0;
    req_if.ip_addr     = '0;
    req_if.login_user  = '0;
    rsp_if.ready       = 1'b0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // unknown keys, create, login, slot reuse, ignored ops
    send_request(sta_pkg::OP_QUERY, k_zero, 16'sd0);
    send_request(sta_pkg::OP_LOGOUT, k_zero, 16'sd0);
    send_request(sta_pkg::OP_TOUCH, k_zero, 16'sd0);
    send_request(sta_pkg::OP_LOGIN, k_ones, 16'sd32767);
    send_request(sta_pkg::OP_QUERY, k_ones, 16'sd0);
    send_request(sta_pkg::OP_LOGIN, k_zero, sta_pkg::NONE_USER);
    send_request(sta_pkg::OP_LOGIN, k_zero, 16'sd0);
    send_request(sta_pkg::OP_QUERY, k_zero, 16'sd0);
    send_request(sta_pkg::OP_TOUCH, k_zero, sta_pkg::NONE_USER);
    send_request(sta_pkg::OP_LOGOUT, k_zero, 16'sd0);
    send_request(sta_pkg::OP_QUERY, k_zero, 16'sd0);
    send_request(sta_pkg::OP_TOUCH, k_alt_a, 16'sd0);
    send_request(sta_pkg::OP_LOGIN, k_alt_b, 16'sh2AAA);
    send_request(sta_pkg::OP_LOGIN, k_alt_a, 16'sh5555);
    send_request(sta_pkg::OP_TICK, k_zero, 16'sd0);
    send_request(sta_pkg::OP_SWEEP, k_zero, 16'sd0);
    send_request(OP_UNUSED_LO, k_ones, sta_pkg::NONE_USER);
    send_request(OP_UNUSED_HI, k_ones, sta_pkg::NONE_USER);
    send_request(sta_pkg::OP_LOGOUT, k_ones, 16'sd0);
    send_request(sta_pkg::OP_QUERY, k_ones, 16'sd0);

    write_timeout(16'd0);
    run_traffic(100, 16, 1'b1, 1'b0);
    // table fills up and overflows
    write_timeout(16'hFFFF);
    run_traffic(150, 96, 1'b0, 1'b1);
    write_timeout(16'd7);
    run_traffic(110, 24, 1'b1, 1'b0);
    write_timeout(16'($urandom_range(1, 40)));
    run_traffic(90, 40, 1'b1, 1'b0);
    write_timeout(sta_pkg::TIMEOUT_RESET);
    run_traffic(80, 64, 1'b1, 1'b0);

    req_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (SESSION_SLOTS + 8) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
